>>> rtl/core/rpm_pkg.sv
// rpm_pkg: shared widths, codes and types of the rigid pose to matrix block
`default_nettype none

package rpm_pkg;

	// field widths
	localparam int ROT_W   = 16;
	localparam int POS_W   = 32;
	localparam int SCALE_W = 32;

	// units scale after reset: 1.0 in unsigned Q16.16
	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd65536;

	// command code for the inverse (view) matrix; the other code is the model matrix
	localparam logic CMD_VIEW = 1'b1;

	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [POS_W-1:0] pos_t;

	// load enables of the four pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} adv_t;

endpackage

`default_nettype wire

>>> rtl/core/rpm_rot.sv
// rpm_rot: quaternion products and rounded, saturated rotation entries (stages 1 and 2)
`default_nettype none

module rpm_rot (
	input  wire logic          clk,
	input  wire rpm_pkg::adv_t adv,
	input  wire logic          cmd_s1,
	input  wire rpm_pkg::rot_t quat_w,
	input  wire rpm_pkg::rot_t quat_x,
	input  wire rpm_pkg::rot_t quat_y,
	input  wire rpm_pkg::rot_t quat_z,
	output rpm_pkg::rot_t      rot_s2 [9]
);
	import rpm_pkg::*;

	localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

	logic signed [31:0] xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [35:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
	logic signed [35:0] ent [9];

	// round half up from Q4.28 to Q2.14 and clamp to 16 bits
	function automatic rot_t rnd_sat(input logic signed [35:0] v);
		logic signed [35:0] t;
		logic signed [21:0] sh;
		t  = v + 36'sd8192;
		sh = $signed(t[35:14]);
		if (sh > 22'sd32767)
			return 16'sh7fff;
		else if (sh < -22'sd32768)
			return 16'sh8000;
		else
			return sh[15:0];
	endfunction

	// stage 1: the nine component products, exact in Q4.28
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			xx_s1 <= 32'(quat_x) * 32'(quat_x);
			yy_s1 <= 32'(quat_y) * 32'(quat_y);
			zz_s1 <= 32'(quat_z) * 32'(quat_z);
			xy_s1 <= 32'(quat_x) * 32'(quat_y);
			xz_s1 <= 32'(quat_x) * 32'(quat_z);
			yz_s1 <= 32'(quat_y) * 32'(quat_z);
			wx_s1 <= 32'(quat_w) * 32'(quat_x);
			wy_s1 <= 32'(quat_w) * 32'(quat_y);
			wz_s1 <= 32'(quat_w) * 32'(quat_z);
		end
	end

	// conjugate flips the sign of the scalar-vector products only
	always_comb begin
		xx = 36'(xx_s1);
		yy = 36'(yy_s1);
		zz = 36'(zz_s1);
		xy = 36'(xy_s1);
		xz = 36'(xz_s1);
		yz = 36'(yz_s1);
		wx = (cmd_s1 == CMD_VIEW) ? -36'(wx_s1) : 36'(wx_s1);
		wy = (cmd_s1 == CMD_VIEW) ? -36'(wy_s1) : 36'(wy_s1);
		wz = (cmd_s1 == CMD_VIEW) ? -36'(wz_s1) : 36'(wz_s1);

		ent[0] = ONE_Q28 - ((yy + zz) <<< 1);
		ent[1] = (xy + wz) <<< 1;
		ent[2] = (xz - wy) <<< 1;
		ent[3] = (xy - wz) <<< 1;
		ent[4] = ONE_Q28 - ((xx + zz) <<< 1);
		ent[5] = (wx + yz) <<< 1;
		ent[6] = (wy + xz) <<< 1;
		ent[7] = (yz - wx) <<< 1;
		ent[8] = ONE_Q28 - ((xx + yy) <<< 1);
	end

	// stage 2: rounded matrix entries
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int i = 0; i < 9; i++)
				rot_s2[i] <= rnd_sat(ent[i]);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rpm_pos.sv
// rpm_pos: position times units scale, rounded and saturated (stages 1 and 2)
`default_nettype none

module rpm_pos (
	input  wire logic                         clk,
	input  wire rpm_pkg::adv_t                adv,
	input  wire logic [rpm_pkg::SCALE_W-1:0]  units_scale,
	input  wire rpm_pkg::pos_t                pos_x,
	input  wire rpm_pkg::pos_t                pos_y,
	input  wire rpm_pkg::pos_t                pos_z,
	output rpm_pkg::pos_t                     p_s2 [3]
);
	import rpm_pkg::*;

	logic signed [64:0] prod_s1 [3];

	// round half up from Q32.32 to Q16.16 and clamp to 32 bits
	function automatic pos_t rnd_sat(input logic signed [64:0] v);
		logic signed [65:0] t;
		logic signed [49:0] sh;
		t  = {v[64], v} + 66'sd32768;
		sh = $signed(t[65:16]);
		if (sh > 50'sd2147483647)
			return 32'sh7fffffff;
		else if (sh < -50'sd2147483648)
			return 32'sh80000000;
		else
			return sh[31:0];
	endfunction

	// stage 1: signed position times unsigned scale
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			prod_s1[0] <= 65'(pos_x) * 65'($signed({1'b0, units_scale}));
			prod_s1[1] <= 65'(pos_y) * 65'($signed({1'b0, units_scale}));
			prod_s1[2] <= 65'(pos_z) * 65'($signed({1'b0, units_scale}));
		end
	end

	// stage 2: scaled position in game units
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int i = 0; i < 3; i++)
				p_s2[i] <= rnd_sat(prod_s1[i]);
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rpm_xlat.sv
// rpm_xlat: view translation from rotation columns and the final result register (stages 3 and 4)
`default_nettype none

module rpm_xlat (
	input  wire logic          clk,
	input  wire rpm_pkg::adv_t adv,
	input  wire logic          cmd_s2,
	input  wire rpm_pkg::pos_t p_s2 [3],
	input  wire rpm_pkg::rot_t rot_s2 [9],
	output rpm_pkg::rot_t      rot_s4 [9],
	output rpm_pkg::pos_t      trans_s4 [3]
);
	import rpm_pkg::*;

	logic               cmd_s3;
	pos_t               p_s3 [3];
	rot_t               rot_s3 [9];
	logic signed [47:0] m_s3 [9];
	pos_t               view_t [3];

	// round half up from Q18.30 to Q16.16 of the negated sum and clamp to 32 bits
	function automatic pos_t neg_rnd_sat(input logic signed [49:0] s);
		logic signed [50:0] t;
		logic signed [36:0] sh;
		t  = -51'(s) + 51'sd8192;
		sh = $signed(t[50:14]);
		if (sh > 37'sd2147483647)
			return 32'sh7fffffff;
		else if (sh < -37'sd2147483648)
			return 32'sh80000000;
		else
			return sh[31:0];
	endfunction

	// stage 3: position component times matching rotation row entry
	always_ff @(posedge clk) begin
		if (adv.s3) begin
			cmd_s3 <= cmd_s2;
			for (int k = 0; k < 3; k++) begin
				p_s3[k] <= p_s2[k];
				for (int c = 0; c < 3; c++)
					m_s3[3*k+c] <= 48'(p_s2[k]) * 48'(rot_s2[3*k+c]);
			end
			for (int i = 0; i < 9; i++)
				rot_s3[i] <= rot_s2[i];
		end
	end

	// column sums of the products
	always_comb begin
		for (int c = 0; c < 3; c++)
			view_t[c] = neg_rnd_sat(50'(m_s3[c]) + 50'(m_s3[3+c]) + 50'(m_s3[6+c]));
	end

	// stage 4: result register, translation picked by command
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			for (int c = 0; c < 3; c++)
				trans_s4[c] <= (cmd_s3 == CMD_VIEW) ? view_t[c] : p_s3[c];
			for (int i = 0; i < 9; i++)
				rot_s4[i] <= rot_s3[i];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rigid_pose_to_matrix.sv
// rigid_pose_to_matrix: pose to rigid transform top level with pipeline control
//
// Input channel (in_valid / in_stall) takes one pose: cmd, quaternion quat_w..quat_z
// in Q2.14 and position pos_x..pos_z in Q16.16 metres. cmd selects the model matrix
// or the view (inverse) matrix. Output channel (out_valid / out_stall) returns the
// nine rotation entries rot_r*_c* in Q2.14 and translation trans_x..trans_z in
// Q16.16 game units; the last column (0,0,0,1) is implied.
// units_scale_we / units_scale_wdata write the units scale (unsigned Q16.16); write
// it only while no pose is in flight.
// Four register stages: a transferred pose loads stage 1, then stages 2, 3 and 4 in
// turn; out_valid rises once it sits in stage 4. Stage 1 multiplies, stage 2 rounds
// the rotation and scaled position, stage 3 multiplies position by rotation, stage 4
// sums and holds the result. Throughput is one pose per cycle while out_stall is low.
// Reset clears all stage valids and sets the units scale to 1.0.
// While out_stall holds a result, earlier stages keep filling any empty slot; once
// every stage holds a pose, in_stall rises in the same cycle. Nothing is dropped.
`default_nettype none

module rigid_pose_to_matrix (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         cmd,
	input  wire rpm_pkg::rot_t                quat_w,
	input  wire rpm_pkg::rot_t                quat_x,
	input  wire rpm_pkg::rot_t                quat_y,
	input  wire rpm_pkg::rot_t                quat_z,
	input  wire rpm_pkg::pos_t                pos_x,
	input  wire rpm_pkg::pos_t                pos_y,
	input  wire rpm_pkg::pos_t                pos_z,
	input  wire logic                         units_scale_we,
	input  wire logic [rpm_pkg::SCALE_W-1:0]  units_scale_wdata,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output rpm_pkg::rot_t                     rot_r0_c0,
	output rpm_pkg::rot_t                     rot_r0_c1,
	output rpm_pkg::rot_t                     rot_r0_c2,
	output rpm_pkg::rot_t                     rot_r1_c0,
	output rpm_pkg::rot_t                     rot_r1_c1,
	output rpm_pkg::rot_t                     rot_r1_c2,
	output rpm_pkg::rot_t                     rot_r2_c0,
	output rpm_pkg::rot_t                     rot_r2_c1,
	output rpm_pkg::rot_t                     rot_r2_c2,
	output rpm_pkg::pos_t                     trans_x,
	output rpm_pkg::pos_t                     trans_y,
	output rpm_pkg::pos_t                     trans_z
);
	import rpm_pkg::*;

	logic [SCALE_W-1:0] units_scale_q;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic               cmd_s1, cmd_s2;
	adv_t               adv;
	rot_t               rot_s2 [9];
	rot_t               rot_s4 [9];
	pos_t               p_s2 [3];
	pos_t               trans_s4 [3];

	// units scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			units_scale_q <= SCALE_RESET;
		else if (units_scale_we)
			units_scale_q <= units_scale_wdata;
	end

	// a stage loads when it is empty or its contents move on
	always_comb begin
		adv.s4 = !v_s4 || !out_stall;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv.s1 = !v_s1 || adv.s2;
	end

	assign in_stall  = !adv.s1;
	assign out_valid = v_s4;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv.s1) v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
		end
	end

	// command travels alongside the data
	always_ff @(posedge clk) begin
		if (adv.s1) cmd_s1 <= cmd;
		if (adv.s2) cmd_s2 <= cmd_s1;
	end

	rpm_rot u_rot (
		.clk    (clk),
		.adv    (adv),
		.cmd_s1 (cmd_s1),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.rot_s2 (rot_s2)
	);

	rpm_pos u_pos (
		.clk         (clk),
		.adv         (adv),
		.units_scale (units_scale_q),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.p_s2        (p_s2)
	);

	rpm_xlat u_xlat (
		.clk      (clk),
		.adv      (adv),
		.cmd_s2   (cmd_s2),
		.p_s2     (p_s2),
		.rot_s2   (rot_s2),
		.rot_s4   (rot_s4),
		.trans_s4 (trans_s4)
	);

	// result fields
	assign rot_r0_c0 = rot_s4[0];
	assign rot_r0_c1 = rot_s4[1];
	assign rot_r0_c2 = rot_s4[2];
	assign rot_r1_c0 = rot_s4[3];
	assign rot_r1_c1 = rot_s4[4];
	assign rot_r1_c2 = rot_s4[5];
	assign rot_r2_c0 = rot_s4[6];
	assign rot_r2_c1 = rot_s4[7];
	assign rot_r2_c2 = rot_s4[8];
	assign trans_x   = trans_s4[0];
	assign trans_y   = trans_s4[1];
	assign trans_z   = trans_s4[2];

endmodule

`default_nettype wire

>>> rtl/core/rpm_checker.sv
// rpm_checker: port-level assertions on the rigid pose to matrix block, bound to the top level
`default_nettype none

module rpm_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_stall,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [rpm_pkg::ROT_W-1:0]    rot_r0_c0,
	input wire logic [rpm_pkg::POS_W-1:0]    trans_x
);

	// no result shows while reset is held
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

	// input only backs up when the output side holds a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output side free");

	// a transfer reaches the output when out_stall stays low while it moves through the stages
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(rot_r0_c0) && $stable(trans_x)))
		else $error("stalled result changed");

endmodule

bind rigid_pose_to_matrix rpm_checker u_rpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.rot_r0_c0 (rot_r0_c0),
	.trans_x   (trans_x)
);

`default_nettype wire

>>> tb/rigid_pose_to_matrix_check.sv
// rigid_pose_to_matrix_check: watches both channels, predicts each matrix and compares it
module rigid_pose_to_matrix_check
	import rpm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire logic                cmd,
	input  rot_t                     quat_w,
	input  rot_t                     quat_x,
	input  rot_t                     quat_y,
	input  rot_t                     quat_z,
	input  pos_t                     pos_x,
	input  pos_t                     pos_y,
	input  pos_t                     pos_z,
	input  wire logic                units_scale_we,
	input  wire logic [SCALE_W-1:0]  units_scale_wdata,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  rot_t                     rot_r0_c0,
	input  rot_t                     rot_r0_c1,
	input  rot_t                     rot_r0_c2,
	input  rot_t                     rot_r1_c0,
	input  rot_t                     rot_r1_c1,
	input  rot_t                     rot_r1_c2,
	input  rot_t                     rot_r2_c0,
	input  rot_t                     rot_r2_c1,
	input  rot_t                     rot_r2_c2,
	input  pos_t                     trans_x,
	input  pos_t                     trans_y,
	input  pos_t                     trans_z,
	output int                       mismatches,
	output int                       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ROT_MIN = -(longint'(1) << (ROT_W - 1));
	localparam longint ROT_MAX = (longint'(1) << (ROT_W - 1)) - 1;
	localparam longint POS_MIN = -(longint'(1) << (POS_W - 1));
	localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
	localparam int MAX_REPORTS = 10;

	// rotation entries in row-major order, translation x..z
	typedef struct packed {
		logic [8:0][ROT_W-1:0] rot;
		logic [2:0][POS_W-1:0] trans;
	} matrix_t;

	matrix_t expected_matrices[$];
	matrix_t got;
	matrix_t want;
	logic [SCALE_W-1:0] scale_shadow;

	initial mismatches = 0;

	// divide by 2^s, rounding half toward plus infinity
	function automatic longint round_shift(input longint v, input int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rigid transform of one pose at the given units scale
	function automatic matrix_t pose_to_matrix(input logic view, input rot_t qw, input rot_t qx,
			input rot_t qy, input rot_t qz, input pos_t px, input pos_t py, input pos_t pz,
			input logic [SCALE_W-1:0] scale);
		longint one;
		longint w, x, y, z;
		longint prod[9];
		longint rot[9];
		longint p[3];
		longint s;
		matrix_t m;
		one = longint'(1) << 28;
		w = qw;
		x = qx;
		y = qy;
		z = qz;
		// conjugate keeps the negated -32768 at full width
		if (view == CMD_VIEW) begin
			x = -x;
			y = -y;
			z = -z;
		end
		prod[0] = one - 2 * (y * y + z * z);
		prod[1] = 2 * (x * y + w * z);
		prod[2] = 2 * (x * z - w * y);
		prod[3] = 2 * (x * y - w * z);
		prod[4] = one - 2 * (x * x + z * z);
		prod[5] = 2 * (w * x + y * z);
		prod[6] = 2 * (w * y + x * z);
		prod[7] = 2 * (y * z - w * x);
		prod[8] = one - 2 * (x * x + y * y);
		for (int i = 0; i < 9; i++) begin
			rot[i] = clamp(round_shift(prod[i], 14), ROT_MIN, ROT_MAX);
			m.rot[i] = rot_t'(rot[i]);
		end
		// scaled position, Q32.32 back to Q16.16
		p[0] = clamp(round_shift(longint'(px) * longint'(scale), 16), POS_MIN, POS_MAX);
		p[1] = clamp(round_shift(longint'(py) * longint'(scale), 16), POS_MIN, POS_MAX);
		p[2] = clamp(round_shift(longint'(pz) * longint'(scale), 16), POS_MIN, POS_MAX);
		for (int c = 0; c < 3; c++) begin
			if (view == CMD_VIEW) begin
				s = p[0] * rot[c] + p[1] * rot[3 + c] + p[2] * rot[6 + c];
				m.trans[c] = pos_t'(clamp(round_shift(-s, 14), POS_MIN, POS_MAX));
			end else begin
				m.trans[c] = pos_t'(p[c]);
			end
		end
		return m;
	endfunction

	task automatic compare_field(input string field, input longint exp_val, input longint act_val);
		if (exp_val != act_val) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch %s: expected %0d, got %0d", field, exp_val, act_val);
		end
	endtask

	// score output transfers, queue predictions for input transfers, track the scale register
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_matrices.delete();
			scale_shadow = SCALE_RESET;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.rot = {rot_r2_c2, rot_r2_c1, rot_r2_c0, rot_r1_c2, rot_r1_c1, rot_r1_c0,
					rot_r0_c2, rot_r0_c1, rot_r0_c0};
				got.trans = {trans_z, trans_y, trans_x};
				if (expected_matrices.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected output transfer with no pose in flight");
				end else begin
					want = expected_matrices.pop_front();
					for (int i = 0; i < 9; i++)
						compare_field($sformatf("rot_r%0d_c%0d", i / 3, i % 3),
							$signed(want.rot[i]), $signed(got.rot[i]));
					for (int c = 0; c < 3; c++)
						compare_field($sformatf("trans_%s", c == 0 ? "x" : (c == 1 ? "y" : "z")),
							$signed(want.trans[c]), $signed(got.trans[c]));
				end
			end
			if (in_valid && !in_stall)
				expected_matrices.push_back(pose_to_matrix(cmd, quat_w, quat_x, quat_y, quat_z,
					pos_x, pos_y, pos_z, scale_shadow));
			if (units_scale_we)
				scale_shadow = units_scale_wdata;
			outstanding <= expected_matrices.size();
		end
	end

endmodule

>>> tb/rigid_pose_to_matrix_test.sv
// rigid_pose_to_matrix_test: clock, reset, pose stimulus, scale writes and the verdict
module rigid_pose_to_matrix_test
	import rpm_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_POSES = 110;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic cmd;
	rot_t quat_w, quat_x, quat_y, quat_z;
	pos_t pos_x, pos_y, pos_z;
	logic units_scale_we;
	logic [SCALE_W-1:0] units_scale_wdata;
	logic out_valid;
	logic out_stall;
	rot_t rot_r0_c0, rot_r0_c1, rot_r0_c2;
	rot_t rot_r1_c0, rot_r1_c1, rot_r1_c2;
	rot_t rot_r2_c0, rot_r2_c1, rot_r2_c2;
	pos_t trans_x, trans_y, trans_z;
	int mismatches;
	int outstanding;
	bit idle_en;
	int idle_cycles;

	rigid_pose_to_matrix uut (.*);

	rigid_pose_to_matrix_check pose_check (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// output back-pressure in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (!idle_en) begin
				stall_left = 0;
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic rot_t extreme_rot();
		case ($urandom_range(0, 4))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd0;
			3: return 16'sd16384;
			default: return -16'sd16384;
		endcase
	endfunction

	// mostly modest positions, some full range and some at the rails
	function automatic pos_t random_pos();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			1, 2: return pos_t'($urandom);
			3, 4: return pos_t'($urandom_range(0, 1 << 17) - (1 << 16));
			default: return pos_t'($urandom_range(0, 1 << 25) - (1 << 24));
		endcase
	endfunction

	// one pose transfer, with an optional gap in front
	task automatic send(input logic view, input rot_t w, input rot_t x, input rot_t y,
			input rot_t z, input pos_t px, input pos_t py, input pos_t pz);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= view;
		quat_w <= w;
		quat_x <= x;
		quat_y <= y;
		quat_z <= z;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (in_stall);
	endtask

	// mostly unit quaternions, the rest raw bits or extreme components
	task automatic send_random_pose();
		int a[4];
		real norm;
		rot_t q[4];
		int kind;
		kind = $urandom_range(0, 15);
		for (int i = 0; i < 4; i++)
			a[i] = $urandom_range(0, 32768) - 16384;
		norm = $sqrt(real'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3]));
		for (int i = 0; i < 4; i++) begin
			if (kind >= 14)
				q[i] = extreme_rot();
			else if (kind >= 11)
				q[i] = rot_t'($urandom);
			else if (norm < 1.0)
				q[i] = (i == 0) ? 16'sd16384 : 16'sd0;
			else
				q[i] = rot_t'($rtoi(real'(a[i]) * 16384.0 / norm));
		end
		send($urandom_range(0, 1) ? CMD_VIEW : ~CMD_VIEW, q[0], q[1], q[2], q[3],
			random_pos(), random_pos(), random_pos());
	endtask

	// stop sending and wait until every predicted matrix has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_scale(input logic [SCALE_W-1:0] value);
		wait_drained();
		units_scale_we <= 1'b1;
		units_scale_wdata <= value;
		@(posedge clk);
		units_scale_we <= 1'b0;
	endtask

	// stimulus and verdict
	initial begin
		logic [SCALE_W-1:0] scale;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= 1'b0;
		quat_w <= '0;
		quat_x <= '0;
		quat_y <= '0;
		quat_z <= '0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		units_scale_we <= 1'b0;
		units_scale_wdata <= '0;
		idle_en = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed poses at the reset scale
		idle_en = 1'b1;
		send(~CMD_VIEW, 16384, 0, 0, 0, 0, 0, 0);
		send(CMD_VIEW, 16384, 0, 0, 0, 32'sd65536, -32'sd65536, 32'sd12345);
		send(~CMD_VIEW, 16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd1);
		send(CMD_VIEW, 16384, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd1);
		send(~CMD_VIEW, -32768, -32768, -32768, -32768, 32'h7FFF_FFFF, 32'sd1, 32'h8000_0000);
		send(CMD_VIEW, -32768, -32768, -32768, -32768, 32'h7FFF_FFFF, 32'sd1, 32'h8000_0000);
		send(~CMD_VIEW, 32767, 32767, 32767, 32767, 32'sd65536, 32'sd65536, 32'sd65536);
		send(CMD_VIEW, 32767, 32767, 32767, 32767, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send(~CMD_VIEW, 11585, 0, 0, 11585, 32'sd65536, 32'sd131072, -32'sd196608);
		send(CMD_VIEW, 11585, 0, 0, 11585, 32'sd65536, 32'sd131072, -32'sd196608);
		send(CMD_VIEW, 0, 16384, 0, 0, 32'sd3, -32'sd5, 32'sd7);
		send(~CMD_VIEW, 0, 0, 16384, 0, -32'sd70000, 32'sd0, 32'sd70000);
		send(CMD_VIEW, 0, 0, 0, -16384, 32'sd100000, 32'sd200000, 32'sd300000);
		send(CMD_VIEW, 8192, 8192, 8192, 8192, 32'sd65536, -32'sd32768, 32'sd32769);
		send(~CMD_VIEW, -16384, 0, 0, 0, -32'sd65536, 32'sd1, -32'sd1);
		send(CMD_VIEW, 0, -32768, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536);
		send(~CMD_VIEW, 0, 0, 0, 0, 32'sd12345, -32'sd12345, 32'sd0);
		send(CMD_VIEW, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send(CMD_VIEW, rot_t'($urandom), rot_t'($urandom), rot_t'($urandom), rot_t'($urandom),
			pos_t'($urandom), pos_t'($urandom), pos_t'($urandom));
		send(~CMD_VIEW, rot_t'($urandom), rot_t'($urandom), rot_t'($urandom), rot_t'($urandom),
			pos_t'($urandom), pos_t'($urandom), pos_t'($urandom));

		// random poses across several units scales, extremes included
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: scale = 32'h0000_0000;
				1: scale = 32'hFFFF_FFFF;
				2: scale = 32'h0000_0001;
				3: scale = 32'h0000_8000;
				4: scale = 32'h0064_0000;
				5: scale = $urandom;
				default: scale = 32'h0001_0000;
			endcase
			write_scale(scale);
			for (int n = 0; n < PHASE_POSES; n++) begin
				if (n % 20 == 0)
					idle_en = ($urandom_range(0, 3) != 0);
				// final stretch runs back to back
				if (ph == 6 && n >= 10)
					idle_en = 1'b0;
				// sender holds off until the pipeline is empty
				if (ph == 3 && n == PHASE_POSES / 2)
					wait_drained();
				send_random_pose();
			end
		end

		wait_drained();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
